@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define PTT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define PTT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

@@ hw/rtl/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// ptt_pkg
// Types, widths and codes of the point-in-triangle test core.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int FRACTION_BITS = 16;
  localparam int TOL_W         = 31;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

  // Derived arithmetic widths.
  localparam int EW     = COORD_WIDTH + 1;   // coordinate difference
  localparam int PW     = 2 * EW;            // product of two differences
  localparam int NW     = PW + 1;            // normal component
  localparam int SQ_W   = 2 * NW;            // squared normal component
  localparam int NN_W   = SQ_W + 2;          // squared normal length
  localparam int TOL2_W = 2 * TOL_W;

  // Digit widths of the staged multipliers and their stage counts.
  localparam int SQ_DW      = 16;
  localparam int SQ_STAGES  = (NW + SQ_DW - 1) / SQ_DW;
  localparam int RHS_DW     = 8;
  localparam int RHS_STAGES = (TOL2_W + RHS_DW - 1) / RHS_DW;
  localparam int PTT_LATENCY = SQ_STAGES + RHS_STAGES + 8;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    EDGE_NONE  = 2'd0,
    EDGE_ABOVE = 2'd1,
    EDGE_BELOW = 2'd2,
    EDGE_ON    = 2'd3
  } edge_class_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] first_z;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] second_z;
    logic signed [COORD_WIDTH-1:0] third_x;
    logic signed [COORD_WIDTH-1:0] third_y;
    logic signed [COORD_WIDTH-1:0] third_z;
  } ptt_req_t;

  typedef struct packed {
    logic  contained;
    logic  on_edge;
    axis_t projection_axis;
  } ptt_rsp_t;

endpackage

@@ hw/rtl/ptt_mul.sv @@
// ----------------------------------------------------------------------------
// ptt_mul
// Pipelined unsigned multiplier that consumes one digit of b per stage and
// carries a sideband word alongside the product.
// ----------------------------------------------------------------------------
module ptt_mul #(
  parameter int A_W = 32,
  parameter int B_W = 32,
  parameter int D_W = 8,
  parameter int S_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [A_W-1:0]   in_a,
  input  logic [B_W-1:0]   in_b,
  input  logic [S_W-1:0]   in_side,
  output logic             out_valid,
  output logic [A_W+B_W-1:0] out_prod,
  output logic [S_W-1:0]   out_side
);

  localparam int STAGES = (B_W + D_W - 1) / D_W;
  localparam int P_W    = A_W + B_W;
  localparam int BP_W   = STAGES * D_W;
  localparam int PP_W   = A_W + D_W;

  logic [STAGES-1:0] v_r;
  logic [P_W-1:0]    acc_r  [STAGES];
  logic [A_W-1:0]    a_r    [STAGES];
  logic [BP_W-1:0]   b_r    [STAGES];
  logic [S_W-1:0]    side_r [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic            v_in;
    logic [P_W-1:0]  acc_in;
    logic [A_W-1:0]  a_in;
    logic [BP_W-1:0] b_in;
    logic [S_W-1:0]  side_in;
    logic [PP_W-1:0] pp;
    logic [P_W-1:0]  acc_nxt;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign acc_in  = '0;
      assign a_in    = in_a;
      assign b_in    = BP_W'(in_b);
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign acc_in  = acc_r[k-1];
      assign a_in    = a_r[k-1];
      assign b_in    = b_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign pp      = PP_W'(a_in) * PP_W'(b_in[k*D_W +: D_W]);
    assign acc_nxt = acc_in + (P_W'(pp) << (k * D_W));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      acc_r[k]  <= acc_nxt;
      side_r[k] <= side_in;
    end

    if (k < STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        a_r[k] <= a_in;
        b_r[k] <= b_in;
      end
    end
  end

  assign out_valid = v_r[STAGES-1];
  assign out_prod  = acc_r[STAGES-1];
  assign out_side  = side_r[STAGES-1];

endmodule

@@ hw/rtl/point_in_triangle_test_core.sv @@
// ----------------------------------------------------------------------------
// point_in_triangle_test_core
// Throughput: one request per cycle; busy stays low, results are never held.
// The depth is set by the staged squaring of the normal and the tolerance
// product. Synchronous active-low reset clears the valid bits and sets the
// tolerance to one; requests in flight are dropped.
// ----------------------------------------------------------------------------
module point_in_triangle_test_core #(
  parameter int FRACTION_BITS = ptt_pkg::FRACTION_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  ptt_pkg::ptt_req_t         in_req,
  output logic                      out_strobe,
  output ptt_pkg::ptt_rsp_t         out_rsp,
  input  logic                      cfg_wr_en,
  input  logic [ptt_pkg::TOL_W-1:0] cfg_wr_data
);

  import ptt_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int REQ_W  = $bits(ptt_req_t);
  localparam int HALF_W = REQ_W / 2;
  localparam int RHS_W  = NN_W + TOL2_W;
  localparam int LHS_W  = SQ_W + 2 * FRACTION_BITS;
  localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int RT_W   = EW + TOL_W;
  localparam int XW     = (2 * EW + 2 > RT_W + 2) ? 2 * EW + 2 : RT_W + 2;
  localparam int RS_W   = 2 * SQ_W + TOL_W + REQ_W;

  function automatic logic signed [CW-1:0] get_coord(ptt_req_t r, logic [3:0] idx);
    logic signed [CW-1:0] c;
    case (idx)
      4'd0:    c = r.point_x;
      4'd1:    c = r.point_y;
      4'd2:    c = r.point_z;
      4'd3:    c = r.first_x;
      4'd4:    c = r.first_y;
      4'd5:    c = r.first_z;
      4'd6:    c = r.second_x;
      4'd7:    c = r.second_y;
      4'd8:    c = r.second_z;
      4'd9:    c = r.third_x;
      4'd10:   c = r.third_y;
      4'd11:   c = r.third_z;
      default: c = '0;
    endcase
    return c;
  endfunction

  logic [TOL_W-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  assign busy = 1'b0;

  // Stage 1: edge vectors from the first vertex.
  logic                 v1_r;
  ptt_req_t             req1_r;
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  logic signed [EW-1:0] e1_nxt [3];
  logic signed [EW-1:0] e2_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1_nxt[k] = EW'(get_coord(in_req, 4'(6 + k))) - EW'(get_coord(in_req, 4'(3 + k)));
      e2_nxt[k] = EW'(get_coord(in_req, 4'(9 + k))) - EW'(get_coord(in_req, 4'(3 + k)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    req1_r <= in_req;
    e1_r   <= e1_nxt;
    e2_r   <= e2_nxt;
  end

  // Stage 2: cross product terms.
  logic                 v2_r;
  ptt_req_t             req2_r;
  logic signed [PW-1:0] m_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    req2_r <= req1_r;
    m_r[0] <= PW'(e1_r[1]) * PW'(e2_r[2]);
    m_r[1] <= PW'(e1_r[2]) * PW'(e2_r[1]);
    m_r[2] <= PW'(e1_r[2]) * PW'(e2_r[0]);
    m_r[3] <= PW'(e1_r[0]) * PW'(e2_r[2]);
    m_r[4] <= PW'(e1_r[0]) * PW'(e2_r[1]);
    m_r[5] <= PW'(e1_r[1]) * PW'(e2_r[0]);
  end

  // Stage 3: normal components and their magnitudes.
  logic                 v3_r;
  ptt_req_t             req3_r;
  logic [NW-1:0]        nabs_r [3];
  logic [NW-1:0]        nabs_nxt [3];
  logic signed [NW-1:0] n_c [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n_c[k]      = NW'(m_r[2*k]) - NW'(m_r[2*k+1]);
      nabs_nxt[k] = n_c[k][NW-1] ? NW'(-n_c[k]) : NW'(n_c[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    req3_r <= req2_r;
    nabs_r <= nabs_nxt;
  end

  // Squares of the normal components.
  logic [2:0]        sq_v;
  logic [SQ_W-1:0]   sq [3];
  logic [HALF_W-1:0] sq_hi, sq_lo;
  logic [TOL_W-1:0]  sq_tol;

  ptt_mul #(.A_W(NW), .B_W(NW), .D_W(SQ_DW), .S_W(HALF_W)) u_sq0 (
    .clk, .rst_n, .in_valid(v3_r), .in_a(nabs_r[0]), .in_b(nabs_r[0]),
    .in_side(req3_r[REQ_W-1 -: HALF_W]), .out_valid(sq_v[0]), .out_prod(sq[0]),
    .out_side(sq_hi)
  );

  ptt_mul #(.A_W(NW), .B_W(NW), .D_W(SQ_DW), .S_W(TOL_W)) u_sq1 (
    .clk, .rst_n, .in_valid(v3_r), .in_a(nabs_r[1]), .in_b(nabs_r[1]),
    .in_side(tol_r), .out_valid(sq_v[1]), .out_prod(sq[1]), .out_side(sq_tol)
  );

  ptt_mul #(.A_W(NW), .B_W(NW), .D_W(SQ_DW), .S_W(HALF_W)) u_sq2 (
    .clk, .rst_n, .in_valid(v3_r), .in_a(nabs_r[2]), .in_b(nabs_r[2]),
    .in_side(req3_r[HALF_W-1:0]), .out_valid(sq_v[2]), .out_prod(sq[2]),
    .out_side(sq_lo)
  );

  // Squared length and squared tolerance.
  logic              vq_r;
  ptt_req_t          reqq_r;
  logic [TOL_W-1:0]  tolq_r;
  logic [SQ_W-1:0]   nx2q_r, ny2q_r;
  logic [NN_W-1:0]   nnq_r;
  logic [TOL2_W-1:0] tol2q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r <= 1'b0;
    end else begin
      vq_r <= &sq_v;
    end
  end

  always_ff @(posedge clk) begin
    reqq_r  <= ptt_req_t'({sq_hi, sq_lo});
    tolq_r  <= sq_tol;
    nx2q_r  <= sq[0];
    ny2q_r  <= sq[1];
    nnq_r   <= NN_W'(sq[0]) + NN_W'(sq[1]) + NN_W'(sq[2]);
    tol2q_r <= TOL2_W'(sq_tol) * TOL2_W'(sq_tol);
  end

  // Squared tolerance times the squared length.
  logic             rv;
  logic [RHS_W-1:0] rhs;
  logic [RS_W-1:0]  rside;

  ptt_mul #(.A_W(NN_W), .B_W(TOL2_W), .D_W(RHS_DW), .S_W(RS_W)) u_rhs (
    .clk, .rst_n, .in_valid(vq_r), .in_a(nnq_r), .in_b(tol2q_r),
    .in_side({nx2q_r, ny2q_r, tolq_r, reqq_r}), .out_valid(rv), .out_prod(rhs),
    .out_side(rside)
  );

  // Axis choice.
  logic             vc_r;
  ptt_req_t         reqc_r;
  logic [TOL_W-1:0] tolc_r;
  axis_t            axisc_r;
  axis_t            axis_nxt;
  logic [CMP_W-1:0] lhs_x, lhs_y, rhs_c;

  always_comb begin
    lhs_x = CMP_W'(rside[RS_W-1 -: SQ_W]) << (2 * FRACTION_BITS);
    lhs_y = CMP_W'(rside[RS_W-SQ_W-1 -: SQ_W]) << (2 * FRACTION_BITS);
    rhs_c = CMP_W'(rhs);
    if (lhs_x > rhs_c) begin
      axis_nxt = AXIS_X;
    end else if (lhs_y > rhs_c) begin
      axis_nxt = AXIS_Y;
    end else begin
      axis_nxt = AXIS_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= rv;
    end
  end

  always_ff @(posedge clk) begin
    reqc_r  <= ptt_req_t'(rside[REQ_W-1:0]);
    tolc_r  <= rside[REQ_W+TOL_W-1 -: TOL_W];
    axisc_r <= axis_nxt;
  end

  // Edge stage 1: projection, span and range checks, differences.
  logic                 ve1_r;
  axis_t                axise1_r;
  logic [TOL_W-1:0]     tole1_r;
  logic                 ok_r   [3];
  logic signed [EW-1:0] d_r    [3];
  logic [EW-1:0]        ad_r   [3];
  logic signed [EW-1:0] do1_r  [3];
  logic signed [EW-1:0] do2_r  [3];
  logic signed [EW-1:0] da_r   [3];
  logic                 ok_nxt [3];
  logic signed [EW-1:0] d_nxt  [3];
  logic [EW-1:0]        ad_nxt [3];
  logic signed [EW-1:0] do1_nxt[3];
  logic signed [EW-1:0] do2_nxt[3];
  logic signed [EW-1:0] da_nxt [3];

  always_comb begin
    logic [3:0]           ai, oi;
    logic signed [CW-1:0] pa, po, a1, o1, a2, o2;
    ai = (axisc_r == AXIS_X) ? 4'd1 : 4'd0;
    oi = (axisc_r == AXIS_Z) ? 4'd1 : 4'd2;
    pa = get_coord(reqc_r, ai);
    po = get_coord(reqc_r, oi);
    for (int i = 0; i < 3; i++) begin
      a1 = get_coord(reqc_r, 4'(3 + 3 * i) + ai);
      o1 = get_coord(reqc_r, 4'(3 + 3 * i) + oi);
      a2 = get_coord(reqc_r, 4'((i == 2) ? 3 : 6 + 3 * i) + ai);
      o2 = get_coord(reqc_r, 4'((i == 2) ? 3 : 6 + 3 * i) + oi);
      d_nxt[i]   = EW'(a2) - EW'(a1);
      ad_nxt[i]  = d_nxt[i][EW-1] ? EW'(-d_nxt[i]) : EW'(d_nxt[i]);
      ok_nxt[i]  = (ad_nxt[i] > tolc_r) &&
                   ((pa >= a1 && pa <= a2) || (pa <= a1 && pa >= a2));
      do1_nxt[i] = EW'(o1) - EW'(po);
      do2_nxt[i] = EW'(o2) - EW'(o1);
      da_nxt[i]  = EW'(pa) - EW'(a1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve1_r <= 1'b0;
    end else begin
      ve1_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    axise1_r <= axisc_r;
    tole1_r  <= tolc_r;
    ok_r     <= ok_nxt;
    d_r      <= d_nxt;
    ad_r     <= ad_nxt;
    do1_r    <= do1_nxt;
    do2_r    <= do2_nxt;
    da_r     <= da_nxt;
  end

  // Edge stage 2: cross terms and the scaled tolerance band.
  logic                 ve2_r;
  axis_t                axise2_r;
  logic                 ok2_r  [3];
  logic                 dneg_r [3];
  logic signed [PW-1:0] p1_r   [3];
  logic signed [PW-1:0] p2_r   [3];
  logic [RT_W-1:0]      rt_r   [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve2_r <= 1'b0;
    end else begin
      ve2_r <= ve1_r;
    end
  end

  always_ff @(posedge clk) begin
    axise2_r <= axise1_r;
    for (int i = 0; i < 3; i++) begin
      ok2_r[i]  <= ok_r[i];
      dneg_r[i] <= d_r[i][EW-1];
      p1_r[i]   <= PW'(do1_r[i]) * PW'(d_r[i]);
      p2_r[i]   <= PW'(do2_r[i]) * PW'(da_r[i]);
      rt_r[i]   <= RT_W'(ad_r[i]) * RT_W'(tole1_r);
    end
  end

  // Edge stage 3: classification and the combined result.
  logic                 vo_r;
  ptt_rsp_t             rsp_r;
  ptt_rsp_t             rsp_nxt;
  edge_class_t          cls [3];

  always_comb begin
    logic signed [XW-1:0] num, s, r;
    logic                 up, down, on;
    up   = 1'b0;
    down = 1'b0;
    on   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      num = XW'(p1_r[i]) + XW'(p2_r[i]);
      s   = dneg_r[i] ? -num : num;
      r   = $signed(XW'(rt_r[i]));
      if (!ok2_r[i]) begin
        cls[i] = EDGE_NONE;
      end else if (s > r) begin
        cls[i] = EDGE_ABOVE;
      end else if (s < -r) begin
        cls[i] = EDGE_BELOW;
      end else begin
        cls[i] = EDGE_ON;
      end
      up   = up   | (cls[i] == EDGE_ABOVE);
      down = down | (cls[i] == EDGE_BELOW);
      on   = on   | (cls[i] == EDGE_ON);
    end
    rsp_nxt.contained       = (up && down) || on;
    rsp_nxt.on_edge         = on;
    rsp_nxt.projection_axis = axise2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= ve2_r;
    end
  end

  always_ff @(posedge clk) begin
    rsp_r <= rsp_nxt;
  end

  assign out_strobe = vo_r;
  assign out_rsp    = rsp_r;

endmodule

@@ hw/rtl/ptt_checker.sv @@
// ----------------------------------------------------------------------------
// ptt_checker
// Port-level timing and result checks of the point-in-triangle test core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_strobe,
  input ptt_pkg::ptt_rsp_t out_rsp
);

  import ptt_pkg::*;

  // Every accepted request yields exactly one result a fixed time later.
  `PTT_ASSERT(a_req_to_rsp, (start && !busy) |-> ##PTT_LATENCY out_strobe)
  `PTT_ASSERT(a_rsp_from_req, out_strobe |-> $past(start && !busy, PTT_LATENCY))
  // A point found on an edge is always reported as contained.
  `PTT_ASSERT(a_on_contained, (out_strobe && out_rsp.on_edge) |-> out_rsp.contained)
  // Reset flushes the pipeline.
  `PTT_ASSERT_ALWAYS(a_reset_flush, $past(!rst_n) |-> !out_strobe)

endmodule

bind point_in_triangle_test_core ptt_checker u_ptt_checker (.*);
